// File: rtl/core/hv_supply_ramp_controller_unit_assert.svh
// Assertion macros for the HV supply ramp controller.
// Each use expands to one labeled concurrent assertion on clk.
`ifndef HV_SUPPLY_RAMP_CONTROLLER_UNIT_ASSERT_SVH
`define HV_SUPPLY_RAMP_CONTROLLER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define HVSRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hv ramp controller assertion failed");

// Checked at every edge, reset included.
`define HVSRC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hv ramp controller assertion failed");

`endif

// File: rtl/core/hvsrc_pkg.sv
// ----------------------------------------------------------------------------
// hvsrc_pkg
// Types and constants shared by the HV supply ramp controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvsrc_pkg;

    localparam int CFG_BITS   = 12;
    localparam int DRIVE_BITS = 12;
    localparam int VALUE_BITS = 16;

    localparam logic [CFG_BITS-1:0] CAL_LIMIT = 12'd4000;

    // commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_SWITCH_ON  = 2'd1;
    localparam logic [1:0] CMD_SWITCH_OFF = 2'd2;
    localparam logic [1:0] CMD_SET_TARGET = 2'd3;

    // supply status codes
    localparam logic [2:0] ST_OFF   = 3'd0;
    localparam logic [2:0] ST_ON    = 3'd1;
    localparam logic [2:0] ST_UP    = 3'd2;
    localparam logic [2:0] ST_DOWN  = 3'd3;
    localparam logic [2:0] ST_ILOCK = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_TARGET     = 2'd0;
    localparam logic [1:0] CFG_RAMP_UP_STEP   = 2'd1;
    localparam logic [1:0] CFG_RAMP_DOWN_STEP = 2'd2;

    typedef struct packed {
        logic [CFG_BITS-1:0] max_target;
        logic [CFG_BITS-1:0] ramp_up_step;
        logic [CFG_BITS-1:0] ramp_down_step;
    } cfg_t;

    typedef struct packed {
        logic       run_on;
        logic [2:0] status;
        logic       request;
    } ctrl_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [VALUE_BITS-1:0] value;
        logic                  calibration;
        logic                  control_enabled;
        logic                  output_mismatch;
        logic                  output_fault;
    } item_t;

endpackage

// File: rtl/core/hvsrc_step.sv
// ----------------------------------------------------------------------------
// hvsrc_step
// Next-state logic for one command: switch on/off, target clamp, snap and per-tick ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvsrc_step #(
    parameter int LEVEL_BITS = 12
) (
    input  hvsrc_pkg::item_t      item,
    input  hvsrc_pkg::cfg_t       cfg,
    input  hvsrc_pkg::ctrl_t      ctrl,
    input  logic [LEVEL_BITS-1:0] cur_level,
    input  logic [LEVEL_BITS-1:0] tgt_level,
    output hvsrc_pkg::ctrl_t      ctrl_next,
    output logic [LEVEL_BITS-1:0] cur_level_next,
    output logic [LEVEL_BITS-1:0] tgt_level_next,
    output logic                  status_changed
);

    logic [LEVEL_BITS-1:0]           up_step;
    logic [LEVEL_BITS-1:0]           down_step;
    logic [LEVEL_BITS-1:0]           lvl;
    logic [LEVEL_BITS-1:0]           tgt;
    logic [LEVEL_BITS-1:0]           diff;
    logic [hvsrc_pkg::CFG_BITS-1:0]  lim;
    logic [hvsrc_pkg::VALUE_BITS-1:0] lim_wide;
    logic [hvsrc_pkg::VALUE_BITS-1:0] clamped;
    hvsrc_pkg::ctrl_t                c;

    assign up_step   = LEVEL_BITS'(cfg.ramp_up_step);
    assign down_step = LEVEL_BITS'(cfg.ramp_down_step);

    always_comb
    begin
        lvl      = cur_level;
        tgt      = tgt_level;
        c        = ctrl;
        diff     = '0;
        lim      = '0;
        lim_wide = '0;
        clamped  = '0;
        case (item.cmd)
            hvsrc_pkg::CMD_TICK:
            begin
                if (!item.control_enabled)
                begin
                    lvl      = '0;
                    c.status = hvsrc_pkg::ST_ILOCK;
                end
                else
                begin
                    if (item.output_mismatch || item.output_fault)
                    begin
                        lvl      = '0;
                        c.run_on = c.request;
                    end
                    if (item.output_fault)
                        c.status = hvsrc_pkg::ST_ILOCK;
                    if (c.run_on)
                    begin
                        if (c.status != hvsrc_pkg::ST_ILOCK)
                        begin
                            if (tgt > lvl)
                            begin
                                c.status = hvsrc_pkg::ST_UP;
                                diff     = tgt - lvl;
                                lvl      = lvl + ((diff < up_step) ? diff : up_step);
                            end
                            else if (tgt < lvl)
                            begin
                                c.status = hvsrc_pkg::ST_DOWN;
                                diff     = lvl - tgt;
                                lvl      = lvl - ((diff < down_step) ? diff : down_step);
                            end
                            else
                                c.status = hvsrc_pkg::ST_ON;
                        end
                    end
                    else if (lvl != '0)
                    begin
                        c.status = hvsrc_pkg::ST_DOWN;
                        lvl      = lvl - ((lvl < down_step) ? lvl : down_step);
                    end
                    else
                    begin
                        // request drops only on the tick that first reaches off
                        if (c.status != hvsrc_pkg::ST_OFF)
                            c.request = 1'b0;
                        c.status = hvsrc_pkg::ST_OFF;
                    end
                end
            end
            hvsrc_pkg::CMD_SWITCH_ON:
            begin
                c.request = 1'b1;
                c.run_on  = 1'b1;
            end
            hvsrc_pkg::CMD_SWITCH_OFF:
                c.run_on = 1'b0;
            hvsrc_pkg::CMD_SET_TARGET:
            begin
                if (item.calibration || (cfg.max_target > hvsrc_pkg::CAL_LIMIT))
                    lim = hvsrc_pkg::CAL_LIMIT;
                else
                    lim = cfg.max_target;
                lim_wide = hvsrc_pkg::VALUE_BITS'(lim);
                clamped  = (item.value < lim_wide) ? item.value : lim_wide;
                tgt      = LEVEL_BITS'(clamped[hvsrc_pkg::CFG_BITS-1:0]);
                diff     = (tgt > lvl) ? (tgt - lvl) : (lvl - tgt);
                if (diff < up_step)
                    lvl = tgt;
            end
            default:
                c = ctrl;
        endcase
    end

    assign ctrl_next      = c;
    assign cur_level_next = lvl;
    assign tgt_level_next = tgt;
    assign status_changed = (c.status != ctrl.status);

endmodule

// File: rtl/core/hv_supply_ramp_controller_unit.sv
// ----------------------------------------------------------------------------
// hv_supply_ramp_controller_unit
// Slew-rate limited ramp controller for one high-voltage supply.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser holds the command code (tick, switch on,
//   switch off, set target), tdata the target value and the tick flags.
//   m_axis returns one result transaction per command: drive level, supply
//   status, output request and a status-changed flag.
//   cfg writes max_target (index 0), ramp_up_step (1), ramp_down_step (2);
//   it is always ready; writes are to be made while no command is in flight, the block does not enforce it.
// Path: an accepted command lands in the input register, is evaluated
//   against the stored state and is held in the output register for m_axis.
// Throughput: one command per cycle while m_axis is not stalled; the state
//   update loop (compare, subtract, clamp on the stored level) sets that figure.
// Stall: the input register and the output register each hold one item;
//   with m_axis stalled the block takes up to two more commands, then drops
//   s_axis_tready. Nothing is lost or reordered.
// Reset: rst_n clears the level, target, on/off state, status and request,
//   and loads the configuration defaults (4000, 10, 10). No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hv_supply_ramp_controller_unit_assert.svh"

module hv_supply_ramp_controller_unit #(
    parameter int LEVEL_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] value, [16] calibration, [17] control_enabled,
    // [18] output_mismatch, [19] output_fault, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] drive_level, [14:12] supply_status, [15] output_request,
    // [16] status_changed, [23:17] zero
    output logic [23:0] m_axis_tdata,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    hvsrc_pkg::cfg_t       cfg_reg;
    hvsrc_pkg::ctrl_t      ctrl_reg;
    hvsrc_pkg::ctrl_t      ctrl_next;
    logic [LEVEL_BITS-1:0] cur_level_reg;
    logic [LEVEL_BITS-1:0] cur_level_next;
    logic [LEVEL_BITS-1:0] tgt_level_reg;
    logic [LEVEL_BITS-1:0] tgt_level_next;
    logic                  changed_next;

    hvsrc_pkg::item_t      item_reg;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic [23:0]           out_data_reg;
    logic                  advance;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_target     <= hvsrc_pkg::CAL_LIMIT;
            cfg_reg.ramp_up_step   <= 12'd10;
            cfg_reg.ramp_down_step <= 12'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hvsrc_pkg::CFG_MAX_TARGET:     cfg_reg.max_target     <= cfg_data;
                hvsrc_pkg::CFG_RAMP_UP_STEP:   cfg_reg.ramp_up_step   <= cfg_data;
                hvsrc_pkg::CFG_RAMP_DOWN_STEP: cfg_reg.ramp_down_step <= cfg_data;
                default:                       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.cmd             <= s_axis_tuser;
            item_reg.value           <= s_axis_tdata[15:0];
            item_reg.calibration     <= s_axis_tdata[16];
            item_reg.control_enabled <= s_axis_tdata[17];
            item_reg.output_mismatch <= s_axis_tdata[18];
            item_reg.output_fault    <= s_axis_tdata[19];
        end
    end

    hvsrc_step #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_step (
        .item           (item_reg),
        .cfg            (cfg_reg),
        .ctrl           (ctrl_reg),
        .cur_level      (cur_level_reg),
        .tgt_level      (tgt_level_reg),
        .ctrl_next      (ctrl_next),
        .cur_level_next (cur_level_next),
        .tgt_level_next (tgt_level_next),
        .status_changed (changed_next)
    );

    // supply state, committed as each command moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.run_on  <= 1'b0;
            ctrl_reg.status  <= hvsrc_pkg::ST_OFF;
            ctrl_reg.request <= 1'b0;
            cur_level_reg    <= '0;
            tgt_level_reg    <= '0;
        end
        else if (advance)
        begin
            ctrl_reg      <= ctrl_next;
            cur_level_reg <= cur_level_next;
            tgt_level_reg <= tgt_level_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {7'd0, changed_next, ctrl_next.request, ctrl_next.status,
                             cur_level_next[hvsrc_pkg::DRIVE_BITS-1:0]};
    end

    `HVSRC_ASSERT(a_level_in_range,
        cur_level_reg <= LEVEL_BITS'(hvsrc_pkg::CAL_LIMIT))
    `HVSRC_ASSERT(a_target_in_range,
        tgt_level_reg <= LEVEL_BITS'(hvsrc_pkg::CAL_LIMIT))
    `HVSRC_ASSERT(a_request_drops_at_off,
        $fell(ctrl_reg.request) |-> (ctrl_reg.status == hvsrc_pkg::ST_OFF))
    `HVSRC_ASSERT(a_held_item_kept,
        (in_valid_reg && !advance) |=> in_valid_reg)
    `HVSRC_ASSERT_ALWAYS(a_advance_fills_output,
        (rst_n && advance) |=> (out_valid_reg || !rst_n))

endmodule
